// ===== rtl/core/grz4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grz4_pkg: shared types, constants and helpers for the GR(4, n) ALU
// Element layout, operation codes, register indexes and Z4 plane arithmetic.
// ----------------------------------------------------------------------------
package grz4_pkg;

   localparam int MAX_DEGREE  = 32;
   localparam int DEG_W       = 6;
   localparam int COEF_W      = 32;            // coefficients per element plane
   localparam int QUOT_W      = COEF_W + 1;    // Barrett quotient reaches degree n
   localparam int PROD_W      = COEF_W + QUOT_W - 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = QUOT_W;
   localparam int OP_W        = 2;
   localparam int NUM_STAGES  = 10;

   // Operation codes carried in tuser; the fourth code yields zero.
   localparam logic [OP_W-1:0] OP_MUL = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD = 2'd1;
   localparam logic [OP_W-1:0] OP_NEG = 2'd2;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_DEGREE        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS_TAIL  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUOTIENT_LOW  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUOTIENT_HIGH = 2'd3;

   // Polynomial over Z4 as two bit planes; coefficient i = lo[i] + 2*hi[i]
   typedef struct packed {
      logic [PROD_W-1:0] hi;
      logic [PROD_W-1:0] lo;
   } z4_poly_type;

   // Data that rides beside the multiplier chain
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COEF_W-1:0] hi;
      logic [COEF_W-1:0] lo;
   } side_type;

   // Coefficient-wise add in Z4
   function automatic z4_poly_type z4_add(input z4_poly_type x, input z4_poly_type y);
      z4_poly_type r;
      r.lo = x.lo ^ y.lo;
      r.hi = x.hi ^ y.hi ^ (x.lo & y.lo);
      return r;
   endfunction

   // Coefficient-wise negate in Z4
   function automatic z4_poly_type z4_neg(input z4_poly_type x);
      z4_poly_type r;
      r.lo = x.lo;
      r.hi = x.hi ^ x.lo;
      return r;
   endfunction

   // Clamp the degree register to 1..MAX_DEGREE
   function automatic logic [DEG_W-1:0] eff_degree(input logic [DEG_W-1:0] d);
      logic [DEG_W-1:0] n;
      n = d;
      if (d == '0) begin
         n = DEG_W'(1);
      end else if (d > DEG_W'(MAX_DEGREE)) begin
         n = DEG_W'(MAX_DEGREE);
      end
      return n;
   endfunction

   // Mask of the n low coefficients
   function automatic logic [COEF_W-1:0] coef_mask(input logic [DEG_W-1:0] n);
      logic [COEF_W:0] wide;
      wide = ~({(COEF_W + 1){1'b1}} << n);
      return wide[COEF_W-1:0];
   endfunction

endpackage

// ===== rtl/core/grz4_poly_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grz4_poly_mul: two-stage Z4 polynomial multiplier
// Forms the shifted partial products of x by each coefficient of y, sums them
// in groups in the first stage and folds the group sums in the second.
// ----------------------------------------------------------------------------
module grz4_poly_mul (
   input  logic                        clock,
   input  logic [1:0]                  stage_en,   // load enables: group sums, product
   input  logic [grz4_pkg::COEF_W-1:0] x_lo,
   input  logic [grz4_pkg::COEF_W-1:0] x_hi,
   input  logic [grz4_pkg::QUOT_W-1:0] y_lo,
   input  logic [grz4_pkg::QUOT_W-1:0] y_hi,
   output grz4_pkg::z4_poly_type       product
);

   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = (grz4_pkg::QUOT_W + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int NUM_SLOTS  = NUM_GROUPS * GROUP_SIZE;

   logic [grz4_pkg::PROD_W-1:0] x_lo_ext;
   logic [grz4_pkg::PROD_W-1:0] x_hi_ext;
   logic [NUM_SLOTS-1:0]        y_lo_ext;
   logic [NUM_SLOTS-1:0]        y_hi_ext;

   grz4_pkg::z4_poly_type term [NUM_SLOTS];
   grz4_pkg::z4_poly_type group_sum_in [NUM_GROUPS];
   grz4_pkg::z4_poly_type group_sum_ff [NUM_GROUPS];
   grz4_pkg::z4_poly_type product_in;
   grz4_pkg::z4_poly_type product_ff;

   assign x_lo_ext = grz4_pkg::PROD_W'(x_lo);
   assign x_hi_ext = grz4_pkg::PROD_W'(x_hi);
   assign y_lo_ext = NUM_SLOTS'(y_lo);
   assign y_hi_ext = NUM_SLOTS'(y_hi);

   // Partial product for coefficient i of y: (y0 + 2*y1) * x, shifted by i
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         term[i].lo = y_lo_ext[i] ? (x_lo_ext << i) : '0;
         term[i].hi = (y_lo_ext[i] ? (x_hi_ext << i) : '0)
                    ^ (y_hi_ext[i] ? (x_lo_ext << i) : '0);
      end
   end

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_sum_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            group_sum_in[g] = grz4_pkg::z4_add(group_sum_in[g], term[g * GROUP_SIZE + j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            group_sum_ff[g] <= group_sum_in[g];
         end
      end
   end

   always_comb begin
      product_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         product_in = grz4_pkg::z4_add(product_in, group_sum_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

// ===== rtl/core/galois_ring_z4_alu_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// galois_ring_z4_alu_unit: add, negate and Barrett-reduced multiply in GR(4, n)
// Elements are two bit planes (coefficient = low + 2*high mod 4). Multiply
// forms the Z4 product, then reduces it with a software-supplied quotient.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// req_*     in         tuser: req_type; tdata: a_low, a_high, b_low, b_high
// rsp_*     out        tdata: result_low, result_high
// csr_*     in         csr_index selects degree, modulus_tail, quotient_low/high
//
// Ten register stages, one item per cycle while the result side keeps up.
// Three chained Z4 multipliers, two stages each, set the depth.
// Each stage holds while its successor is full and stalled; bubbles close up.
// Reset clears all valid bits and the registers to degree 1, others zero.
// csr writes, always taken, act at once on the stages using them; write only when empty.
// ----------------------------------------------------------------------------
module galois_ring_z4_alu_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [1:0]                       req_tuser,   // [1:0] req_type
   input  logic [127:0]                     req_tdata,   // a_low, a_high, b_low, b_high
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [63:0]                      rsp_tdata,   // result_low, result_high
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [grz4_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [grz4_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int N  = grz4_pkg::NUM_STAGES;
   localparam int CW = grz4_pkg::COEF_W;

   // Stage map
   localparam int ST_ENTRY = 0;   // masked operands, add/negate result
   localparam int ST_MUL1  = 1;   // product a*b, stages 1..2
   localparam int ST_SPLIT = 3;   // split into low part and high part
   localparam int ST_MUL2  = 4;   // high part * quotient, stages 4..5
   localparam int ST_SHIFT = 6;   // estimate quotient: shift down by n
   localparam int ST_MUL3  = 7;   // estimate * modulus tail, stages 7..8
   localparam int ST_OUT   = 9;   // subtract and select

   // ---------------------------------------------------------------- registers
   logic [grz4_pkg::DEG_W-1:0]  degree_ff;
   logic [CW-1:0]               modulus_tail_ff;
   logic [grz4_pkg::QUOT_W-1:0] quotient_low_ff;
   logic [grz4_pkg::QUOT_W-1:0] quotient_high_ff;

   logic [grz4_pkg::DEG_W-1:0]  eff_n;
   logic [CW-1:0]               mask;
   logic [grz4_pkg::QUOT_W-1:0] quot_mask;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff        <= grz4_pkg::DEG_W'(1);
         modulus_tail_ff  <= '0;
         quotient_low_ff  <= '0;
         quotient_high_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            grz4_pkg::CSR_DEGREE:        degree_ff        <= csr_data[grz4_pkg::DEG_W-1:0];
            grz4_pkg::CSR_MODULUS_TAIL:  modulus_tail_ff  <= csr_data[CW-1:0];
            grz4_pkg::CSR_QUOTIENT_LOW:  quotient_low_ff  <= csr_data;
            grz4_pkg::CSR_QUOTIENT_HIGH: quotient_high_ff <= csr_data;
         endcase
      end
   end

   // Degree clamps to 1..MAX_DEGREE; quotient keeps n+1 coefficients
   assign eff_n     = grz4_pkg::eff_degree(degree_ff);
   assign mask      = grz4_pkg::coef_mask(eff_n);
   assign quot_mask = {mask, 1'b1};

   // --------------------------------------------------------------- flow control
   logic [N-1:0] valid_ff;
   logic [N-1:0] valid_in;
   logic [N:0]   stage_en;
   logic [N-1:0] held;

   // A stage loads when it is empty or its successor loads
   always_comb begin
      stage_en[N] = rsp_tready;
      for (int k = N - 1; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign valid_in = (stage_en[N-1:0] & {valid_ff[N-2:0], req_tvalid})
                   | (~stage_en[N-1:0] & valid_ff);
   assign held     = valid_ff & ~stage_en[N-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_en[ST_ENTRY];
   assign rsp_tvalid = valid_ff[ST_OUT];

   // ---------------------------------------------------------------- entry
   grz4_pkg::z4_poly_type a_poly, b_poly, early_poly;
   grz4_pkg::side_type    side_in  [N-1];
   grz4_pkg::side_type    side_ff  [N-1];
   logic [CW-1:0]         a_lo_ff, a_hi_ff, b_lo_ff, b_hi_ff;

   // Drop operand bits at or above n
   always_comb begin
      a_poly.lo = grz4_pkg::PROD_W'(req_tdata[CW-1:0]      & mask);
      a_poly.hi = grz4_pkg::PROD_W'(req_tdata[2*CW-1:CW]   & mask);
      b_poly.lo = grz4_pkg::PROD_W'(req_tdata[3*CW-1:2*CW] & mask);
      b_poly.hi = grz4_pkg::PROD_W'(req_tdata[4*CW-1:3*CW] & mask);
      unique case (req_tuser)
         grz4_pkg::OP_ADD: early_poly = grz4_pkg::z4_add(a_poly, b_poly);
         grz4_pkg::OP_NEG: early_poly = grz4_pkg::z4_neg(a_poly);
         default:          early_poly = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_ENTRY]) begin
         a_lo_ff <= a_poly.lo[CW-1:0];
         a_hi_ff <= a_poly.hi[CW-1:0];
         b_lo_ff <= b_poly.lo[CW-1:0];
         b_hi_ff <= b_poly.hi[CW-1:0];
      end
   end

   // --------------------------------------------------------------- product a*b
   grz4_pkg::z4_poly_type prod1, prod2, prod3;

   grz4_poly_mul u_mul_ab (
      .clock    (clock),
      .stage_en (stage_en[ST_MUL1+1:ST_MUL1]),
      .x_lo     (a_lo_ff),
      .x_hi     (a_hi_ff),
      .y_lo     (grz4_pkg::QUOT_W'(b_lo_ff)),
      .y_hi     (grz4_pkg::QUOT_W'(b_hi_ff)),
      .product  (prod1)
   );

   // --------------------------------------------------------------- split
   logic [grz4_pkg::PROD_W-1:0] top_lo_shift, top_hi_shift;
   logic [CW-1:0]               top_lo_ff, top_hi_ff;

   assign top_lo_shift = prod1.lo >> eff_n;
   assign top_hi_shift = prod1.hi >> eff_n;

   always_ff @(posedge clock) begin
      if (stage_en[ST_SPLIT]) begin
         top_lo_ff <= top_lo_shift[CW-1:0];
         top_hi_ff <= top_hi_shift[CW-1:0];
      end
   end

   // Side lane: entry result, replaced for multiplies by the product's low part at the split
   always_comb begin
      side_in[ST_ENTRY].op = req_tuser;
      side_in[ST_ENTRY].lo = early_poly.lo[CW-1:0];
      side_in[ST_ENTRY].hi = early_poly.hi[CW-1:0];
      for (int k = 1; k < N - 1; k++) begin
         side_in[k] = side_ff[k-1];
      end
      if (side_ff[ST_SPLIT-1].op == grz4_pkg::OP_MUL) begin
         side_in[ST_SPLIT].lo = prod1.lo[CW-1:0] & mask;
         side_in[ST_SPLIT].hi = prod1.hi[CW-1:0] & mask;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N - 1; k++) begin
         if (stage_en[k]) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   // --------------------------------------------------------------- high * quotient
   grz4_poly_mul u_mul_quot (
      .clock    (clock),
      .stage_en (stage_en[ST_MUL2+1:ST_MUL2]),
      .x_lo     (top_lo_ff),
      .x_hi     (top_hi_ff),
      .y_lo     (quotient_low_ff & quot_mask),
      .y_hi     (quotient_high_ff & quot_mask),
      .product  (prod2)
   );

   // --------------------------------------------------------------- estimate
   logic [grz4_pkg::PROD_W-1:0] est_lo_shift, est_hi_shift;
   logic [CW-1:0]               est_lo_ff, est_hi_ff;

   assign est_lo_shift = prod2.lo >> eff_n;
   assign est_hi_shift = prod2.hi >> eff_n;

   always_ff @(posedge clock) begin
      if (stage_en[ST_SHIFT]) begin
         est_lo_ff <= est_lo_shift[CW-1:0];
         est_hi_ff <= est_hi_shift[CW-1:0];
      end
   end

   // --------------------------------------------------------------- estimate * tail
   grz4_poly_mul u_mul_tail (
      .clock    (clock),
      .stage_en (stage_en[ST_MUL3+1:ST_MUL3]),
      .x_lo     (est_lo_ff),
      .x_hi     (est_hi_ff),
      .y_lo     (grz4_pkg::QUOT_W'(modulus_tail_ff & mask)),
      .y_hi     ('0),
      .product  (prod3)
   );

   // --------------------------------------------------------------- output
   grz4_pkg::z4_poly_type low_part, correction, reduced;
   grz4_pkg::side_type    last_side;
   logic [CW-1:0]         result_lo_in, result_hi_in;
   logic [CW-1:0]         result_lo_ff, result_hi_ff;

   // Subtract the Barrett correction from the low part; other operations pass the side lane
   always_comb begin
      last_side     = side_ff[ST_OUT-1];
      low_part.lo   = grz4_pkg::PROD_W'(last_side.lo);
      low_part.hi   = grz4_pkg::PROD_W'(last_side.hi);
      correction.lo = grz4_pkg::PROD_W'(prod3.lo[CW-1:0] & mask);
      correction.hi = grz4_pkg::PROD_W'(prod3.hi[CW-1:0] & mask);
      reduced       = grz4_pkg::z4_add(low_part, grz4_pkg::z4_neg(correction));
      if (last_side.op == grz4_pkg::OP_MUL) begin
         result_lo_in = reduced.lo[CW-1:0] & mask;
         result_hi_in = reduced.hi[CW-1:0] & mask;
      end else begin
         result_lo_in = last_side.lo;
         result_hi_in = last_side.hi;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         result_lo_ff <= result_lo_in;
         result_hi_ff <= result_hi_in;
      end
   end

   assign rsp_tdata = {result_hi_ff, result_lo_ff};

   // --------------------------------------------------------------- assertions
   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0))
      else $error("pipeline not empty after reset");

   a_stall_keeps_items: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((valid_ff & $past(held)) == $past(held)))
      else $error("stalled stage lost its item");

   a_result_from_pipe: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && valid_ff[ST_OUT] && !$past(valid_ff[ST_OUT]))
      |-> $past(valid_ff[ST_OUT-1]))
      else $error("result appeared without an item behind it");

   a_accept_loads_entry: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(req_tvalid && req_tready)) |-> valid_ff[ST_ENTRY])
      else $error("accepted item not held at entry");

endmodule

// ===== tb/galois_ring_z4_alu_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// galois_ring_z4_alu_unit_test: self-checking bench for the GR(4, n) ALU
// Drives add, negate, Barrett-reduced multiply and the spare operation code
// under several register settings. A bit-plane model of the ring predicts
// every result. The sender works in bursts and the receiver stalls, including
// one long hold that backs the pipeline up into the request side.
// ----------------------------------------------------------------------------
module galois_ring_z4_alu_unit_test;

   // The fourth operation code has no package name; it must produce zero.
   localparam logic [grz4_pkg::OP_W-1:0] OP_SPARE = 2'd3;

   localparam int IDLE_LIMIT   = 5000;                        // cycles with no handshake at all
   localparam int DRAIN_CYCLES = grz4_pkg::NUM_STAGES + 4;    // settle time after the last result
   localparam int LONG_HOLD    = 300;                         // receiver hold-off for the fill test
   localparam int PHASE_ITEMS  = 150;
   localparam int NUM_PHASES   = 10;

   // Wide planes hold a full product before reduction
   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } z4_wide_type;

   // One element as it travels on the bus: low plane in the low word
   typedef struct packed {
      logic [grz4_pkg::COEF_W-1:0] hi;
      logic [grz4_pkg::COEF_W-1:0] lo;
   } element_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [1:0]                       req_tuser  = '0;
   logic [127:0]                     req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [63:0]                      rsp_tdata;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [grz4_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [grz4_pkg::CSR_DATA_W-1:0]  csr_data   = '0;

   // Bench copy of the block's registers, updated on each csr handshake
   logic [grz4_pkg::DEG_W-1:0]  ring_degree_reg   = grz4_pkg::DEG_W'(1);
   logic [grz4_pkg::COEF_W-1:0] modulus_tail_reg  = '0;
   logic [grz4_pkg::QUOT_W-1:0] quotient_low_reg  = '0;
   logic [grz4_pkg::QUOT_W-1:0] quotient_high_reg = '0;

   element_type ring_results_due[$];    // predicted results, oldest first
   int          error_count    = 0;
   int          idle_cycles    = 0;
   int          stall_mode     = 0;      // 0 ready, 1 random, 2 fixed pattern
   int          stall_request  = 0;      // set by a test, taken by the receiver
   int          stall_left     = 0;
   int          stall_tick     = 0;

   galois_ring_z4_alu_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Ring arithmetic on bit planes: coefficient i = lo[i] + 2*hi[i] mod 4
   // ------------------------------------------------------------------------
   function automatic logic [63:0] low_mask(input int k);
      return (k >= 64) ? '1 : ((64'd1 << k) - 64'd1);
   endfunction

   function automatic int clamped_degree();
      int n;
      n = int'(ring_degree_reg);
      if (n < 1) begin
         n = 1;
      end else if (n > grz4_pkg::MAX_DEGREE) begin
         n = grz4_pkg::MAX_DEGREE;
      end
      return n;
   endfunction

   function automatic z4_wide_type plane_sum(input z4_wide_type x, input z4_wide_type y);
      z4_wide_type r;
      r.lo = x.lo ^ y.lo;
      r.hi = x.hi ^ y.hi ^ (x.lo & y.lo);
      return r;
   endfunction

   function automatic z4_wide_type plane_negate(input z4_wide_type x);
      z4_wide_type r;
      r.lo = x.lo;
      r.hi = x.hi ^ x.lo;
      return r;
   endfunction

   // GF(2) product, truncated to 64 coefficients
   function automatic logic [63:0] xor_product(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] acc;
      acc = '0;
      for (int i = 0; i < 64; i++) begin
         if (y[i]) begin
            acc ^= x << i;
         end
      end
      return acc;
   endfunction

   // Z4 product: the low plane collects carries into the high plane as terms add
   function automatic z4_wide_type plane_product(input z4_wide_type x, input z4_wide_type y);
      z4_wide_type r;
      logic [63:0] term;
      logic [63:0] carry;
      r.lo  = '0;
      carry = '0;
      for (int i = 0; i < 64; i++) begin
         if (y.lo[i]) begin
            term   = x.lo << i;
            carry ^= term & r.lo;
            r.lo  ^= term;
         end
      end
      r.hi = carry ^ xor_product(x.hi, y.lo) ^ xor_product(x.lo, y.hi);
      return r;
   endfunction

   // Barrett step: low part minus ((high part * Q) >> n) * tail, mod x^n
   function automatic z4_wide_type barrett_fold(input z4_wide_type p, input int n);
      z4_wide_type low_part, high_part, quot, tail, corr;
      logic [63:0] m;
      logic [63:0] qm;
      m  = low_mask(n);
      qm = low_mask(n + 1);
      low_part.lo  = p.lo & m;
      low_part.hi  = p.hi & m;
      high_part.lo = p.lo >> n;
      high_part.hi = p.hi >> n;
      quot.lo = 64'(quotient_low_reg) & qm;
      quot.hi = 64'(quotient_high_reg) & qm;
      corr    = plane_product(high_part, quot);
      corr.lo = corr.lo >> n;
      corr.hi = corr.hi >> n;
      tail.lo = 64'(modulus_tail_reg) & m;
      tail.hi = '0;
      corr    = plane_product(corr, tail);
      corr.lo &= m;
      corr.hi &= m;
      return plane_sum(low_part, plane_negate(corr));
   endfunction

   function automatic element_type predict_ring_op(input logic [grz4_pkg::OP_W-1:0] op,
                                                   input element_type a, input element_type b);
      z4_wide_type x, y, r;
      logic [63:0] m;
      element_type res;
      m    = low_mask(clamped_degree());
      x.lo = 64'(a.lo) & m;
      x.hi = 64'(a.hi) & m;
      y.lo = 64'(b.lo) & m;
      y.hi = 64'(b.hi) & m;
      unique case (op)
         grz4_pkg::OP_MUL: r = barrett_fold(plane_product(x, y), clamped_degree());
         grz4_pkg::OP_ADD: r = plane_sum(x, y);
         grz4_pkg::OP_NEG: r = plane_negate(x);
         default: r = '0;
      endcase
      res.lo = grz4_pkg::COEF_W'(r.lo & m);
      res.hi = grz4_pkg::COEF_W'(r.hi & m);
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Channel tasks
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t mismatch %s: expected %h got %h (degree reg %0d)",
               $realtime, what, want, got, ring_degree_reg);
      error_count++;
   endtask

   // Offer one item; keep valid high afterward so bursts run back to back
   task automatic send_element(input logic [grz4_pkg::OP_W-1:0] op, input element_type a,
                               input element_type b);
      @(negedge clock);
      req_tuser  = op;
      req_tdata  = {b.hi, b.lo, a.hi, a.lo};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ring_results_due.push_back(predict_ring_op(op, a, b));
   endtask

   // Drop valid and stay quiet for the given number of cycles
   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_tvalid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_drained();
      while (ring_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [grz4_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [grz4_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_index = idx;
      csr_data  = data;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      unique case (idx)
         grz4_pkg::CSR_DEGREE:        ring_degree_reg   = data[grz4_pkg::DEG_W-1:0];
         grz4_pkg::CSR_MODULUS_TAIL:  modulus_tail_reg  = data[grz4_pkg::COEF_W-1:0];
         grz4_pkg::CSR_QUOTIENT_LOW:  quotient_low_reg  = data;
         grz4_pkg::CSR_QUOTIENT_HIGH: quotient_high_reg = data;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Drain, then load all four registers; junk above the degree and modulus tail widths
   // must be dropped by the block
   task automatic apply_settings(input logic [grz4_pkg::DEG_W-1:0] deg,
                                 input logic [grz4_pkg::COEF_W-1:0] tail,
                                 input logic [grz4_pkg::QUOT_W-1:0] q_lo,
                                 input logic [grz4_pkg::QUOT_W-1:0] q_hi);
      logic [grz4_pkg::CSR_DATA_W-1:0] junk;
      wait_drained();
      junk = grz4_pkg::CSR_DATA_W'({$urandom, $urandom});
      write_register(grz4_pkg::CSR_DEGREE, {junk[grz4_pkg::CSR_DATA_W-1:grz4_pkg::DEG_W], deg});
      write_register(grz4_pkg::CSR_MODULUS_TAIL, {junk[0], tail});
      write_register(grz4_pkg::CSR_QUOTIENT_LOW, q_lo);
      write_register(grz4_pkg::CSR_QUOTIENT_HIGH, q_hi);
   endtask

   function automatic logic [grz4_pkg::DEG_W-1:0] random_degree();
      unique case ($urandom_range(0, 9))
         0: return grz4_pkg::DEG_W'(0);
         1: return grz4_pkg::DEG_W'(1);
         2: return grz4_pkg::DEG_W'(grz4_pkg::MAX_DEGREE);
         3: return grz4_pkg::DEG_W'($urandom_range(grz4_pkg::MAX_DEGREE + 1, 63));
         4: return grz4_pkg::DEG_W'(2);
         default: return grz4_pkg::DEG_W'($urandom_range(3, grz4_pkg::MAX_DEGREE - 1));
      endcase
   endfunction

   // Mostly dense random planes, with the all-zero and all-one corners mixed in
   function automatic logic [grz4_pkg::COEF_W-1:0] random_plane();
      unique case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return grz4_pkg::COEF_W'($urandom);
      endcase
   endfunction

   function automatic logic [grz4_pkg::QUOT_W-1:0] random_quotient();
      return {1'($urandom_range(0, 1)), grz4_pkg::COEF_W'($urandom)};
   endfunction

   function automatic logic [grz4_pkg::OP_W-1:0] random_op();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
         return grz4_pkg::OP_MUL;
      end else if (pick < 14) begin
         return grz4_pkg::OP_ADD;
      end else if (pick < 18) begin
         return grz4_pkg::OP_NEG;
      end
      return OP_SPARE;
   endfunction

   function automatic element_type random_element();
      element_type e;
      e.lo = random_plane();
      e.hi = random_plane();
      return e;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset values: degree 1 with zero modulus tail and quotient
   task automatic test_reset_state();
      element_type ones;
      ones = '1;
      send_element(grz4_pkg::OP_MUL, ones, ones);
      send_element(grz4_pkg::OP_ADD, ones, ones);
      send_element(grz4_pkg::OP_NEG, ones, '0);
      send_element(OP_SPARE, ones, ones);
      pause_sender(1);
   endtask

   // Field extremes, every operation, clamped degrees and the spare code
   task automatic test_directed_corners();
      element_type ones, zero, three, unit, top;
      ones  = '1;
      zero  = '0;
      three = '{hi: '1, lo: '1};                 // every coefficient is 3
      unit  = '{hi: '0, lo: 32'h0000_0001};
      top   = '{hi: 32'h8000_0000, lo: 32'h8000_0000};

      // Full degree, all tail and quotient bits set
      apply_settings(grz4_pkg::DEG_W'(grz4_pkg::MAX_DEGREE), '1, '1, '1);
      send_element(grz4_pkg::OP_MUL, zero, zero);
      send_element(grz4_pkg::OP_MUL, ones, ones);
      send_element(grz4_pkg::OP_MUL, three, unit);
      send_element(grz4_pkg::OP_MUL, top, top);
      send_element(grz4_pkg::OP_ADD, ones, ones);
      send_element(grz4_pkg::OP_ADD, three, unit);
      send_element(grz4_pkg::OP_NEG, ones, zero);
      send_element(grz4_pkg::OP_NEG, unit, ones);
      send_element(OP_SPARE, ones, ones);
      pause_sender(1);

      // Degree zero behaves as degree one; high operand bits are ignored
      apply_settings(grz4_pkg::DEG_W'(0), 32'h0000_0001, 33'h0_0000_0003, 33'h1_0000_0001);
      send_element(grz4_pkg::OP_MUL, ones, ones);
      send_element(grz4_pkg::OP_ADD, three, three);
      send_element(grz4_pkg::OP_NEG, three, zero);
      pause_sender(1);

      // Degrees above the maximum clamp to it
      apply_settings(grz4_pkg::DEG_W'(63), 32'h8000_00A5, random_quotient(),
                     random_quotient());
      send_element(grz4_pkg::OP_MUL, three, three);
      send_element(grz4_pkg::OP_MUL, top, unit);
      send_element(grz4_pkg::OP_ADD, top, top);
      send_element(grz4_pkg::OP_NEG, top, zero);
      pause_sender(1);
   endtask

   // Random settings per phase; sender bursts and receiver pattern vary too
   task automatic test_random_phases();
      int burst_left;
      bit sender_gaps;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         apply_settings(random_degree(), random_plane(), random_quotient(),
                        random_quotient());
         stall_mode  = phase % 3;
         sender_gaps = (phase % 4) != 0;         // every fourth phase runs flat out
         burst_left  = 0;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (burst_left == 0) begin
               if (sender_gaps) begin
                  pause_sender($urandom_range(1, 8));
               end
               burst_left = $urandom_range(1, 24);
            end
            send_element(random_op(), random_element(), random_element());
            burst_left--;
         end
         pause_sender(1);
      end
   endtask

   // Hold the receiver off long enough for the pipe to fill and stall requests
   task automatic test_receiver_hold();
      apply_settings(grz4_pkg::DEG_W'(grz4_pkg::MAX_DEGREE), random_plane(),
                     random_quotient(), random_quotient());
      stall_mode    = 0;
      stall_request = LONG_HOLD;
      for (int k = 0; k < 40; k++) begin
         send_element(random_op(), random_element(), random_element());
      end
      pause_sender(1);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: ready pattern per mode, plus a one-off hold counted here
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_request != 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      stall_tick++;
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else begin
         unique case (stall_mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = ($urandom_range(0, 3) != 0);
            default: rsp_tready = ((stall_tick % 11) < 7);
         endcase
      end
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_results
      element_type got;
      element_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (ring_results_due.size() == 0) begin
            report_mismatch("result with nothing due", '0, got.lo);
         end else begin
            want = ring_results_due.pop_front();
            if (got.lo !== want.lo) begin
               report_mismatch("result_low", want.lo, got.lo);
            end
            if (got.hi !== want.hi) begin
               report_mismatch("result_high", want.hi, got.hi);
            end
         end
      end
   end

   // Watchdog: end the run when no channel has moved an item for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles, %0d results outstanding",
                  idle_cycles, ring_results_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_directed_corners();
      test_random_phases();
      test_receiver_hold();

      // Let everything outstanding come back, then give the pipe time to settle
      wait_drained();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== galois_ring_z4_alu_unit.f =====
rtl/core/grz4_pkg.sv
rtl/core/grz4_poly_mul.sv
rtl/core/galois_ring_z4_alu_unit.sv
tb/galois_ring_z4_alu_unit_test.sv
